/* sv/i2crtc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2crtc_pkg
// Shared types and constants of the I2C real-time-clock transaction master.
// ----------------------------------------------------------------------------
package i2crtc_pkg;

  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 24;

  typedef logic [1:0] func_t;
  localparam func_t FUNC_TICK  = 2'd0;
  localparam func_t FUNC_WRITE = 2'd1;
  localparam func_t FUNC_READ  = 2'd2;

  localparam logic REG_DEVICE_ADDRESS     = 1'b0;
  localparam logic REG_TIME_BASE_REGISTER = 1'b1;

  localparam logic [6:0] DEVICE_ADDRESS_RESET     = 7'd81;
  localparam logic [7:0] TIME_BASE_REGISTER_RESET = 8'h02;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef enum logic [16:0] {
    PH_IDLE   = 17'b00000000000000001,
    PH_ST1    = 17'b00000000000000010,
    PH_ST2    = 17'b00000000000000100,
    PH_ST3    = 17'b00000000000001000,
    PH_TXSET  = 17'b00000000000010000,
    PH_TXHI   = 17'b00000000000100000,
    PH_TXLO   = 17'b00000000001000000,
    PH_ACKREL = 17'b00000000010000000,
    PH_ACKHI  = 17'b00000000100000000,
    PH_ACKLO  = 17'b00000001000000000,
    PH_RXLO   = 17'b00000010000000000,
    PH_RXHI   = 17'b00000100000000000,
    PH_RXEND  = 17'b00001000000000000,
    PH_SP1    = 17'b00010000000000000,
    PH_SP2    = 17'b00100000000000000,
    PH_SP3    = 17'b01000000000000000,
    PH_SP4    = 17'b10000000000000000
  } phase_t;

  typedef struct packed {
    logic [5:0] hours_raw;
    logic [6:0] minutes_raw;
    logic [6:0] seconds_raw;
    logic       nack_seen;
    logic       active;
    logic       sda_level;
    logic       scl_level;
  } result_t;

  typedef struct packed {
    result_t data;
    logic    done_res;
  } beat_t;

endpackage

/* sv/i2c_rtc_transaction_master.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_rtc_transaction_master
// I2C master sequencer for a real-time clock: register write and time read,
// one bus phase per input beat.
// ----------------------------------------------------------------------------
// Each input beat is taken when s_tready is high and advances the sequencer by one
// bus phase; its result beat is registered in the output register, or in the skid
// register while the output stalls. One beat per clock is sustained while m_tready
// holds; a two-entry output buffer (output register plus skid register) lets one
// more beat enter while a result waits; s_tready drops only when both are full.
module i2c_rtc_transaction_master
  import i2crtc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [7:0]            cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // reg_addr[7:0], wr_data[15:8], sda_in[16], zero[23:17]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // func[1:0]
  input  logic [IN_USER_W-1:0]  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // scl_level[0], sda_level[1], active[2], nack_seen[3], seconds_raw[10:4],
  // minutes_raw[17:11], hours_raw[23:18]
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast
);

  logic [6:0] device_address;
  logic [7:0] time_base_register;

  phase_t     phase, phase_next;
  logic       command_kind, command_kind_next;
  logic [3:0] bit_count, bit_count_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [2:0] byte_index, byte_index_next;
  logic [7:0] held_reg_addr, held_reg_addr_next;
  logic [7:0] held_data, held_data_next;
  logic       nack_flag, nack_flag_next;
  logic [6:0] seconds_reg, seconds_reg_next;
  logic [6:0] minutes_reg, minutes_reg_next;
  logic [5:0] hours_reg, hours_reg_next;
  logic       scl_drive, scl_drive_next;
  logic       sda_drive, sda_drive_next;
  logic       done;

  func_t      func;
  logic [7:0] in_reg_addr;
  logic [7:0] in_wr_data;
  logic       sda_in;
  logic       accept;
  logic [3:0] bit_count_inc;
  logic [2:0] byte_index_inc;

  beat_t      beat_new;
  beat_t      out_beat;
  beat_t      skid_beat;
  logic       out_valid;
  logic       skid_valid;

  assign func        = s_tuser;
  assign in_reg_addr = s_tdata[7:0];
  assign in_wr_data  = s_tdata[15:8];
  assign sda_in      = s_tdata[16];

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;

  assign bit_count_inc  = bit_count + 4'd1;
  assign byte_index_inc = byte_index + 3'd1;

  function automatic logic [7:0] byte_to_send(
    input logic [2:0] idx,
    input logic       kind,
    input logic [6:0] dev,
    input logic [7:0] tbr,
    input logic [7:0] rad,
    input logic [7:0] dat
  );
    logic [7:0] wr;
    wr = {dev, 1'b0};
    if (idx == 3'd0) begin
      return wr;
    end else if (kind == KIND_WRITE) begin
      return (idx == 3'd1) ? rad : dat;
    end else if (idx == 3'd1) begin
      return tbr;
    end
    return {dev, 1'b1};
  endfunction

  always_comb begin
    phase_next         = phase;
    command_kind_next  = command_kind;
    bit_count_next     = bit_count;
    shift_byte_next    = shift_byte;
    byte_index_next    = byte_index;
    held_reg_addr_next = held_reg_addr;
    held_data_next     = held_data;
    nack_flag_next     = nack_flag;
    seconds_reg_next   = seconds_reg;
    minutes_reg_next   = minutes_reg;
    hours_reg_next     = hours_reg;
    scl_drive_next     = scl_drive;
    sda_drive_next     = sda_drive;
    done               = 1'b0;
    unique case (phase)
      PH_IDLE: begin
        if (func == FUNC_WRITE || func == FUNC_READ) begin
          command_kind_next  = (func == FUNC_READ) ? KIND_READ : KIND_WRITE;
          held_reg_addr_next = in_reg_addr;
          held_data_next     = in_wr_data;
          byte_index_next    = 3'd0;
          bit_count_next     = 4'd0;
          sda_drive_next     = 1'b1;
          scl_drive_next     = 1'b1;
          phase_next         = PH_ST2;
        end
      end
      PH_ST1: begin
        sda_drive_next = 1'b1;
        scl_drive_next = 1'b1;
        phase_next     = PH_ST2;
      end
      PH_ST2: begin
        sda_drive_next = 1'b0;
        phase_next     = PH_ST3;
      end
      PH_ST3: begin
        scl_drive_next  = 1'b0;
        shift_byte_next = byte_to_send(byte_index, command_kind, device_address,
                                       time_base_register, held_reg_addr, held_data);
        bit_count_next  = 4'd0;
        phase_next      = PH_TXSET;
      end
      PH_TXSET: begin
        sda_drive_next = shift_byte[7];
        phase_next     = PH_TXHI;
      end
      PH_TXHI: begin
        scl_drive_next = 1'b1;
        phase_next     = PH_TXLO;
      end
      PH_TXLO: begin
        scl_drive_next  = 1'b0;
        shift_byte_next = {shift_byte[6:0], 1'b0};
        bit_count_next  = bit_count_inc;
        phase_next      = (bit_count_inc >= 4'd8) ? PH_ACKREL : PH_TXSET;
      end
      PH_ACKREL: begin
        sda_drive_next = 1'b1;
        phase_next     = PH_ACKHI;
      end
      PH_ACKHI: begin
        scl_drive_next = 1'b1;
        nack_flag_next = sda_in;
        if (command_kind == KIND_READ && byte_index >= 3'd2) begin
          shift_byte_next = 8'd0;
          bit_count_next  = 4'd0;
          phase_next      = PH_RXLO;
        end else if (sda_in) begin
          phase_next = PH_SP1;
        end else begin
          phase_next = PH_ACKLO;
        end
      end
      PH_ACKLO: begin
        scl_drive_next = 1'b0;
        if (command_kind == KIND_WRITE) begin
          if (byte_index < 3'd2) begin
            byte_index_next = byte_index_inc;
            shift_byte_next = byte_to_send(byte_index_inc, command_kind,
                                           device_address, time_base_register,
                                           held_reg_addr, held_data);
            bit_count_next  = 4'd0;
            phase_next      = PH_TXSET;
          end else begin
            phase_next = PH_SP1;
          end
        end else if (byte_index == 3'd0) begin
          byte_index_next = 3'd1;
          shift_byte_next = byte_to_send(3'd1, command_kind, device_address,
                                         time_base_register, held_reg_addr, held_data);
          bit_count_next  = 4'd0;
          phase_next      = PH_TXSET;
        end else begin
          byte_index_next = 3'd2;
          phase_next      = PH_ST1;
        end
      end
      PH_RXLO: begin
        scl_drive_next = 1'b0;
        phase_next     = PH_RXHI;
      end
      PH_RXHI: begin
        scl_drive_next  = 1'b1;
        shift_byte_next = {shift_byte[6:0], sda_in};
        bit_count_next  = bit_count_inc;
        phase_next      = (bit_count_inc >= 4'd8) ? PH_RXEND : PH_RXLO;
      end
      PH_RXEND: begin
        scl_drive_next = 1'b0;
        if (byte_index == 3'd2) begin
          seconds_reg_next = shift_byte[6:0];
        end else if (byte_index == 3'd3) begin
          minutes_reg_next = shift_byte[6:0];
        end else begin
          hours_reg_next = shift_byte[5:0];
        end
        if (byte_index < 3'd4) begin
          byte_index_next = byte_index_inc;
          phase_next      = PH_ST1;
        end else begin
          phase_next = PH_SP1;
        end
      end
      PH_SP1: begin
        sda_drive_next = 1'b0;
        phase_next     = PH_SP2;
      end
      PH_SP2: begin
        scl_drive_next = 1'b1;
        phase_next     = PH_SP3;
      end
      PH_SP3: begin
        sda_drive_next = 1'b1;
        phase_next     = PH_SP4;
      end
      PH_SP4: begin
        scl_drive_next = 1'b0;
        done           = 1'b1;
        phase_next     = PH_IDLE;
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_comb begin
    beat_new.data.scl_level   = scl_drive_next;
    beat_new.data.sda_level   = sda_drive_next;
    beat_new.data.active      = (phase_next != PH_IDLE);
    beat_new.data.nack_seen   = nack_flag_next;
    beat_new.data.seconds_raw = seconds_reg_next;
    beat_new.data.minutes_raw = minutes_reg_next;
    beat_new.data.hours_raw   = hours_reg_next;
    beat_new.done_res         = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address     <= DEVICE_ADDRESS_RESET;
      time_base_register <= TIME_BASE_REGISTER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEVICE_ADDRESS:     device_address     <= cfg_data[6:0];
        REG_TIME_BASE_REGISTER: time_base_register <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      command_kind  <= KIND_WRITE;
      bit_count     <= '0;
      shift_byte    <= '0;
      byte_index    <= '0;
      held_reg_addr <= '0;
      held_data     <= '0;
      nack_flag     <= 1'b0;
      seconds_reg   <= '0;
      minutes_reg   <= '0;
      hours_reg     <= '0;
      scl_drive     <= 1'b1;
      sda_drive     <= 1'b1;
    end else if (accept) begin
      phase         <= phase_next;
      command_kind  <= command_kind_next;
      bit_count     <= bit_count_next;
      shift_byte    <= shift_byte_next;
      byte_index    <= byte_index_next;
      held_reg_addr <= held_reg_addr_next;
      held_data     <= held_data_next;
      nack_flag     <= nack_flag_next;
      seconds_reg   <= seconds_reg_next;
      minutes_reg   <= minutes_reg_next;
      hours_reg     <= hours_reg_next;
      scl_drive     <= scl_drive_next;
      sda_drive     <= sda_drive_next;
    end
  end

  // hold a stalled beat in the skid register, drain it first
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      out_beat <= skid_valid ? skid_beat : beat_new;
    end else if (accept) begin
      skid_beat <= beat_new;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_beat.data;
  assign m_tlast  = out_beat.done_res;

endmodule

/* test/tb_i2c_rtc_transaction_master.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_rtc_transaction_master
// Self-checking bench for the I2C real-time-clock transaction master.
// ----------------------------------------------------------------------------
// Bus steps are queued by a stimulus process and offered by a driver with
// random gaps; a slave stand-in pulls the data line low on acknowledge
// phases, with an occasional refusal. A cycle-accurate copy of the sequencer
// predicts the line levels, flags and time bytes of every step, and the
// monitor checks each result beat against the oldest prediction. Register
// writes happen only with the bus idle and all results back.
// ----------------------------------------------------------------------------
module tb_i2c_rtc_transaction_master;
  import i2crtc_pkg::*;

  localparam func_t FUNC_SPARE = 2'd3;
  localparam int unsigned STEP_TARGET = 1500;

  typedef enum logic [1:0] {
    SLAVE_NONE,
    SLAVE_ACK,
    SLAVE_ACK_RD_NACK
  } slave_mode_t;

  typedef struct {
    func_t       func;
    logic [7:0]  reg_addr;
    logic [7:0]  wr_data;
    logic        sda_in;
    slave_mode_t mode;
  } bus_step_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic                  cfg_index = REG_DEVICE_ADDRESS;
  logic [7:0]            cfg_data = 8'd0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  func_t                 s_tuser = FUNC_TICK;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;

  bus_step_t   bus_steps[$];
  beat_t       expected_bus_states[$];
  int unsigned steps_queued = 0;
  int unsigned steps_accepted = 0;
  int unsigned beats_checked = 0;
  int unsigned mismatches = 0;
  int unsigned send_gap_max = 0;
  int unsigned recv_gap_max = 0;
  int unsigned hold_req = 0;
  int unsigned send_wait = 0;
  int unsigned recv_wait = 0;
  bit          step_taken = 1'b0;
  bit          beat_taken = 1'b0;

  // sequencer copy
  logic [6:0]  dev_addr;
  logic [7:0]  base_reg;
  phase_t      bus_phase = PH_IDLE;
  logic        cmd_kind;
  logic [3:0]  bit_cnt;
  logic [7:0]  shreg;
  logic [2:0]  byte_idx;
  logic [7:0]  held_reg;
  logic [7:0]  held_dat;
  logic        nack_q;
  logic [6:0]  sec_q;
  logic [6:0]  min_q;
  logic [5:0]  hrs_q;
  logic        scl_q;
  logic        sda_q;

  i2c_rtc_transaction_master DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic logic [7:0] tx_byte();
    logic [7:0] wr_byte;
    wr_byte = {dev_addr, 1'b0};
    if (byte_idx == 3'd0) return wr_byte;
    if (cmd_kind == KIND_WRITE) return (byte_idx == 3'd1) ? held_reg : held_dat;
    if (byte_idx == 3'd1) return base_reg;
    return wr_byte | 8'h01;
  endfunction

  task automatic flag_mismatch(string field, logic [7:0] got_v, logic [7:0] want_v);
    $display("beat %0d: %s is %0h, expected %0h", beats_checked, field, got_v, want_v);
    mismatches++;
  endtask

  task automatic queue_step(func_t f, logic [7:0] ra, logic [7:0] wd, logic sda,
                            slave_mode_t m);
    bus_step_t st;
    st.func = f;
    st.reg_addr = ra;
    st.wr_data = wd;
    st.sda_in = sda;
    st.mode = m;
    bus_steps.push_back(st);
    steps_queued++;
  endtask

  task automatic queue_ticks(int unsigned n, slave_mode_t m, int unsigned stray_pct);
    repeat (n) begin
      if ($urandom_range(0, 99) < stray_pct)
        queue_step(func_t'($urandom_range(1, 3)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), m);
      else
        queue_step(FUNC_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)), m);
    end
  endtask

  task automatic drain();
    while (steps_accepted != steps_queued || expected_bus_states.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic finish_transfer();
    drain();
    while (bus_phase != PH_IDLE) begin
      queue_ticks(16, SLAVE_ACK, 0);
      drain();
    end
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // predict one bus step per accepted beat
  always @(posedge clk) begin
    func_t f;
    logic  sin;
    beat_t want;
    if (rst) begin
      dev_addr = DEVICE_ADDRESS_RESET;
      base_reg = TIME_BASE_REGISTER_RESET;
      bus_phase = PH_IDLE;
      cmd_kind = KIND_WRITE;
      bit_cnt = '0;
      shreg = '0;
      byte_idx = '0;
      held_reg = '0;
      held_dat = '0;
      nack_q = 1'b0;
      sec_q = '0;
      min_q = '0;
      hrs_q = '0;
      scl_q = 1'b1;
      sda_q = 1'b1;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_DEVICE_ADDRESS) dev_addr = cfg_data[6:0];
        else base_reg = cfg_data;
      end
      if (s_tvalid && s_tready) begin
        f = s_tuser;
        sin = s_tdata[16];
        want.done_res = 1'b0;
        if (bus_phase == PH_IDLE) begin
          if (f == FUNC_WRITE || f == FUNC_READ) begin
            cmd_kind = (f == FUNC_READ) ? KIND_READ : KIND_WRITE;
            held_reg = s_tdata[7:0];
            held_dat = s_tdata[15:8];
            byte_idx = '0;
            bit_cnt = '0;
            sda_q = 1'b1;
            scl_q = 1'b1;
            bus_phase = PH_ST2;
          end
        end else begin
          case (bus_phase)
            PH_ST1: begin
              sda_q = 1'b1;
              scl_q = 1'b1;
              bus_phase = PH_ST2;
            end
            PH_ST2: begin
              sda_q = 1'b0;
              bus_phase = PH_ST3;
            end
            PH_ST3: begin
              scl_q = 1'b0;
              shreg = tx_byte();
              bit_cnt = '0;
              bus_phase = PH_TXSET;
            end
            PH_TXSET: begin
              sda_q = shreg[7];
              bus_phase = PH_TXHI;
            end
            PH_TXHI: begin
              scl_q = 1'b1;
              bus_phase = PH_TXLO;
            end
            PH_TXLO: begin
              scl_q = 1'b0;
              shreg = {shreg[6:0], 1'b0};
              bit_cnt = bit_cnt + 4'd1;
              bus_phase = (bit_cnt >= 4'd8) ? PH_ACKREL : PH_TXSET;
            end
            PH_ACKREL: begin
              sda_q = 1'b1;
              bus_phase = PH_ACKHI;
            end
            PH_ACKHI: begin
              scl_q = 1'b1;
              nack_q = sin;
              if (cmd_kind == KIND_READ && byte_idx >= 3'd2) begin
                shreg = '0;
                bit_cnt = '0;
                bus_phase = PH_RXLO;
              end else if (sin) begin
                bus_phase = PH_SP1;
              end else begin
                bus_phase = PH_ACKLO;
              end
            end
            PH_ACKLO: begin
              scl_q = 1'b0;
              if (cmd_kind == KIND_WRITE) begin
                if (byte_idx < 3'd2) begin
                  byte_idx = byte_idx + 3'd1;
                  shreg = tx_byte();
                  bit_cnt = '0;
                  bus_phase = PH_TXSET;
                end else begin
                  bus_phase = PH_SP1;
                end
              end else if (byte_idx == 3'd0) begin
                byte_idx = 3'd1;
                shreg = tx_byte();
                bit_cnt = '0;
                bus_phase = PH_TXSET;
              end else begin
                byte_idx = 3'd2;
                bus_phase = PH_ST1;
              end
            end
            PH_RXLO: begin
              scl_q = 1'b0;
              bus_phase = PH_RXHI;
            end
            PH_RXHI: begin
              scl_q = 1'b1;
              shreg = {shreg[6:0], sin};
              bit_cnt = bit_cnt + 4'd1;
              bus_phase = (bit_cnt >= 4'd8) ? PH_RXEND : PH_RXLO;
            end
            PH_RXEND: begin
              scl_q = 1'b0;
              if (byte_idx == 3'd2) sec_q = shreg[6:0];
              else if (byte_idx == 3'd3) min_q = shreg[6:0];
              else hrs_q = shreg[5:0];
              if (byte_idx < 3'd4) begin
                byte_idx = byte_idx + 3'd1;
                bus_phase = PH_ST1;
              end else begin
                bus_phase = PH_SP1;
              end
            end
            PH_SP1: begin
              sda_q = 1'b0;
              bus_phase = PH_SP2;
            end
            PH_SP2: begin
              scl_q = 1'b1;
              bus_phase = PH_SP3;
            end
            PH_SP3: begin
              sda_q = 1'b1;
              bus_phase = PH_SP4;
            end
            PH_SP4: begin
              scl_q = 1'b0;
              want.done_res = 1'b1;
              bus_phase = PH_IDLE;
            end
            default: bus_phase = PH_IDLE;
          endcase
        end
        want.data.scl_level = scl_q;
        want.data.sda_level = sda_q;
        want.data.active = (bus_phase != PH_IDLE);
        want.data.nack_seen = nack_q;
        want.data.seconds_raw = sec_q;
        want.data.minutes_raw = min_q;
        want.data.hours_raw = hrs_q;
        expected_bus_states.push_back(want);
        steps_accepted++;
        step_taken = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    result_t got;
    beat_t   want;
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata);
      if (expected_bus_states.size() == 0) begin
        $display("beat %0d: result beat with no step outstanding", beats_checked);
        mismatches++;
      end else begin
        want = expected_bus_states.pop_front();
        if (got.scl_level !== want.data.scl_level)
          flag_mismatch("scl_level", 8'(got.scl_level), 8'(want.data.scl_level));
        if (got.sda_level !== want.data.sda_level)
          flag_mismatch("sda_level", 8'(got.sda_level), 8'(want.data.sda_level));
        if (got.active !== want.data.active)
          flag_mismatch("active", 8'(got.active), 8'(want.data.active));
        if (got.nack_seen !== want.data.nack_seen)
          flag_mismatch("nack_seen", 8'(got.nack_seen), 8'(want.data.nack_seen));
        if (m_tlast !== want.done_res)
          flag_mismatch("done_res", 8'(m_tlast), 8'(want.done_res));
        if (got.seconds_raw !== want.data.seconds_raw)
          flag_mismatch("seconds_raw", 8'(got.seconds_raw), 8'(want.data.seconds_raw));
        if (got.minutes_raw !== want.data.minutes_raw)
          flag_mismatch("minutes_raw", 8'(got.minutes_raw), 8'(want.data.minutes_raw));
        if (got.hours_raw !== want.data.hours_raw)
          flag_mismatch("hours_raw", 8'(got.hours_raw), 8'(want.data.hours_raw));
      end
      beats_checked++;
      beat_taken = 1'b1;
    end
  end

  // offer the next step; the slave stand-in fills the data line on acknowledge
  always @(negedge clk) begin
    bus_step_t st;
    logic      sda_bit;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || step_taken) begin
      if (step_taken) begin
        step_taken = 1'b0;
      end
      if (send_wait > 0 || bus_steps.size() == 0) begin
        if (send_wait > 0) send_wait--;
        s_tvalid <= 1'b0;
      end else begin
        st = bus_steps.pop_front();
        sda_bit = st.sda_in;
        if (st.mode != SLAVE_NONE && bus_phase == PH_ACKHI) begin
          if (st.mode == SLAVE_ACK_RD_NACK && cmd_kind == KIND_READ && byte_idx >= 3'd2)
            sda_bit = 1'b1;
          else
            sda_bit = ($urandom_range(0, 24) == 0);
        end
        s_tdata <= {7'd0, sda_bit, st.wr_data, st.reg_addr};
        s_tuser <= st.func;
        s_tvalid <= 1'b1;
        send_wait = $urandom_range(0, send_gap_max);
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (hold_req > 0) begin
        recv_wait = hold_req;
        hold_req = 0;
      end else if (beat_taken) begin
        recv_wait = $urandom_range(0, recv_gap_max);
      end
      beat_taken = 1'b0;
      if (recv_wait > 0) begin
        recv_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned sel;
    int unsigned pick;
    bit          first_round;
    func_t       cmd;
    slave_mode_t mode;
    first_round = 1'b1;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // idle bus: ticks and the spare selector change nothing
    queue_step(FUNC_TICK, 8'h00, 8'h00, 1'b0, SLAVE_NONE);
    queue_step(FUNC_TICK, 8'hff, 8'hff, 1'b1, SLAVE_NONE);
    queue_step(FUNC_SPARE, 8'hff, 8'hff, 1'b1, SLAVE_NONE);
    queue_step(FUNC_SPARE, 8'h00, 8'h00, 1'b0, SLAVE_NONE);
    drain();

    write_reg(REG_DEVICE_ADDRESS, 8'h7f);
    write_reg(REG_TIME_BASE_REGISTER, 8'hff);
    queue_step(FUNC_WRITE, 8'hff, 8'h00, 1'b0, SLAVE_ACK);
    queue_step(FUNC_READ, 8'h5a, 8'ha5, 1'b0, SLAVE_ACK);
    finish_transfer();
    queue_step(FUNC_READ, 8'h00, 8'h00, 1'b0, SLAVE_ACK);
    finish_transfer();

    // address refused: straight to stop
    queue_step(FUNC_WRITE, 8'h3c, 8'hc3, 1'b1, SLAVE_NONE);
    repeat (40) queue_step(FUNC_TICK, 8'h00, 8'h00, 1'b1, SLAVE_NONE);
    finish_transfer();

    write_reg(REG_DEVICE_ADDRESS, 8'h00);
    write_reg(REG_TIME_BASE_REGISTER, 8'h00);
    queue_step(FUNC_WRITE, 8'h00, 8'hff, 1'b0, SLAVE_ACK);
    finish_transfer();
    // read address refused: reception goes on regardless
    queue_step(FUNC_READ, 8'hff, 8'hff, 1'b1, SLAVE_ACK_RD_NACK);
    queue_ticks(220, SLAVE_ACK_RD_NACK, 0);
    finish_transfer();

    while (steps_queued < STEP_TARGET) begin
      pick = $urandom_range(0, 3);
      send_gap_max = (pick == 0) ? 0 : (pick == 1) ? 3 : 9;
      pick = $urandom_range(0, 3);
      recv_gap_max = (pick == 0) ? 0 : (pick == 1) ? 3 : 9;
      if (first_round || $urandom_range(0, 9) == 0) begin
        hold_req = $urandom_range(40, 100);
        first_round = 1'b0;
      end
      sel = $urandom_range(0, 99);
      if (sel < 12) begin
        repeat ($urandom_range(4, 30))
          queue_step(func_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), SLAVE_NONE);
      end else begin
        cmd = ($urandom_range(0, 1) == 1) ? FUNC_READ : FUNC_WRITE;
        mode = ($urandom_range(0, 9) == 0) ? SLAVE_ACK_RD_NACK : SLAVE_ACK;
        queue_step(cmd, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)), mode);
        queue_ticks((cmd == FUNC_READ) ? $urandom_range(150, 230) : $urandom_range(60, 110),
                    mode, 3);
      end
      while (bus_steps.size() > 8) @(negedge clk);
      if ($urandom_range(0, 5) == 0) begin
        finish_transfer();
        pick = $urandom_range(0, 3);
        write_reg(REG_DEVICE_ADDRESS, (pick == 0) ? 8'h00 : (pick == 1) ? 8'h7f :
                  8'($urandom_range(0, 127)));
        pick = $urandom_range(0, 3);
        write_reg(REG_TIME_BASE_REGISTER, (pick == 0) ? 8'h00 : (pick == 1) ? 8'hff :
                  8'($urandom_range(0, 255)));
      end
    end

    finish_transfer();
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(4_000_000);
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* files.f */
sv/i2crtc_pkg.sv
sv/i2c_rtc_transaction_master.sv
test/tb_i2c_rtc_transaction_master.sv
